>>> rtl/core/rtc_time_sync_converter_macros.svh
// Assertion macros shared by the time-sync converter RTL.
`ifndef RTC_TIME_SYNC_CONVERTER_MACROS_SVH
`define RTC_TIME_SYNC_CONVERTER_MACROS_SVH
`ifndef ASSERT_OFF
// Checked on every clock edge outside reset.
`define RTSC_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define RTSC_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RTSC_ASSERT(name, prop, msg)
`define RTSC_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

>>> rtl/core/rtsc_pkg.sv
// Types, constants and helper functions of the time-sync converter.
`timescale 1ns / 1ps
`default_nettype none
package rtsc_pkg;

	// Local seconds stay below 2^23: 4294967 s of UTC plus at most 19660 minutes of zone.
	localparam int SECS_W = 23;
	// Whole days in that span fit in 6 bits.
	localparam int DAYS_W = 6;
	// Years walked run from 1970 to 2100.
	localparam int YEAR_W = 12;

	localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;
	localparam logic [YEAR_W-1:0] LAST_YEAR  = 12'd2099;

	localparam logic [SECS_W-1:0] SECS_PER_DAY  = 23'd86400;
	localparam logic [SECS_W-1:0] SECS_PER_HOUR = 23'd3600;
	localparam logic [SECS_W-1:0] SECS_PER_MIN  = 23'd60;

	// ms / 1000 as (ms * MS_RECIP) >> MS_SHIFT, exact over all 32-bit inputs.
	localparam logic [28:0] MS_RECIP = 29'd274877907;
	localparam int          MS_SHIFT = 38;
	localparam int          MS_PROD_W = 61;

	// x / 100 as (x * ZONE_RECIP) >> ZONE_SHIFT, exact for x below 2^21.
	localparam logic [21:0] ZONE_RECIP = 22'd2684355;
	localparam int          ZONE_SHIFT = 28;
	localparam int          ZONE_PROD_W = 43;
	localparam int          ZONE_W = 15;
	localparam logic [ZONE_W-1:0] ZONE_MAX = 15'd19660;

	localparam logic [3:0] LAST_MONTH = 4'd12;

	// One sync message.
	typedef struct packed {
		logic              op;
		logic [31:0]       timestamp_ms;
		logic signed [15:0] tz_hundredths;
		logic [15:0]       cal_year;
		logic [7:0]        cal_month;
		logic [7:0]        cal_day;
		logic [7:0]        cal_hour;
		logic [7:0]        cal_minute;
		logic [7:0]        cal_second;
		logic [7:0]        day_index;
	} in_t;

	// One RTC write.
	typedef struct packed {
		logic        rtc_write;
		logic [15:0] full_year;
		logic [7:0]  rtc_year;
		logic [3:0]  month_out;
		logic [4:0]  day_out;
		logic [4:0]  hour_out;
		logic [5:0]  minute_out;
		logic [5:0]  second_out;
		logic [2:0]  weekday;
		logic        time_valid;
	} out_t;

	// Work handed from front to back: either a finished result or local seconds to convert.
	typedef struct packed {
		logic              conv;
		logic [SECS_W-1:0] secs;
		out_t              res;
	} job_t;

	// Only 2000 is a century year between 1970 and 2099, and it is leap.
	function automatic logic leap_year(input logic [YEAR_W-1:0] y);
		return (y[1:0] == 2'd0);
	endfunction

	function automatic logic [8:0] year_days(input logic [YEAR_W-1:0] y);
		return leap_year(y) ? 9'd366 : 9'd365;
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
		logic [4:0] d;
		d = 5'd31;
		if (mon inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
			d = 5'd30;
		end else if (mon == 4'd2) begin
			d = leap ? 5'd29 : 5'd28;
		end
		return d;
	endfunction

	// Two-digit RTC year, low 8 bits of the offset from 2000 or 1900.
	function automatic logic [7:0] short_year(input logic [15:0] y);
		logic [15:0] d;
		d = '0;
		if (y >= 16'd2000) begin
			d = y - 16'd2000;
		end else if (y >= 16'd1900) begin
			d = y - 16'd1900;
		end
		return d[7:0];
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/rtsc_front.sv
// Front end: takes sync messages, checks calendar fields, scales milliseconds and zone.
`timescale 1ns / 1ps
`default_nettype none
`include "rtc_time_sync_converter_macros.svh"
module rtsc_front import rtsc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  in_t  sync_msg,
	input  logic push,
	output logic full,
	output job_t job,
	output logic job_push,
	input  logic job_full
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv;
	logic accept;

	in_t msg_s1;

	logic              op_s2;
	logic [31:0]       ms_s2;
	logic              neg_s2;
	logic [ZONE_W-1:0] zabs_s2;
	out_t              res_s2;

	logic              op_s3;
	logic [SECS_W-1:0] utc_s3;
	logic              neg_s3;
	logic [ZONE_W-1:0] zabs_s3;
	out_t              res_s3;

	job_t        job_s4;
	logic [15:0] zone_minutes_q;

	// Stage 2 signals
	logic                   tz_neg;
	logic [15:0]            tz_raw;
	logic [15:0]            tz_abs;
	logic [20:0]            tz_x60;
	logic [ZONE_PROD_W-1:0] zone_prod;
	logic                   cal_ok;
	logic [2:0]             wd;
	out_t                   cal_res;

	// Stage 3 signals
	logic [MS_PROD_W-1:0] ms_prod;

	// Stage 4 signals
	logic [20:0]       zsec;
	logic [SECS_W-1:0] zsec_ext;
	logic              neg_bad;
	logic [SECS_W-1:0] secs;
	logic [15:0]       zone_min;
	job_t              job_d;

	// Whole pipeline moves together; it holds only while the last beat waits on the queue
	assign adv      = !(v_s4 && job_full);
	assign full     = !adv;
	assign accept   = push && !full;
	assign job_push = v_s4 && !job_full;
	assign job      = job_s4;

	// Zone magnitude to minutes, calendar check
	always_comb begin
		tz_raw    = msg_s1.tz_hundredths;
		tz_neg    = tz_raw[15];
		tz_abs    = tz_neg ? (16'd0 - tz_raw) : tz_raw;
		tz_x60    = ({5'd0, tz_abs} << 6) - ({5'd0, tz_abs} << 2);
		zone_prod = ZONE_PROD_W'(tz_x60) * ZONE_PROD_W'(ZONE_RECIP);

		cal_ok = (msg_s1.cal_month inside {[8'd1:8'd12]}) &&
			(msg_s1.cal_day inside {[8'd1:8'd31]}) &&
			(msg_s1.cal_hour <= 8'd23) &&
			(msg_s1.cal_minute <= 8'd59) &&
			(msg_s1.cal_second <= 8'd59);

		if (msg_s1.day_index == 8'd0) begin
			wd = 3'd7;
		end else if (msg_s1.day_index <= 8'd6) begin
			wd = msg_s1.day_index[2:0];
		end else begin
			wd = 3'd1;
		end

		cal_res = '0;
		if (cal_ok) begin
			cal_res.rtc_write  = 1'b1;
			cal_res.full_year  = msg_s1.cal_year;
			cal_res.rtc_year   = short_year(msg_s1.cal_year);
			cal_res.month_out  = msg_s1.cal_month[3:0];
			cal_res.day_out    = msg_s1.cal_day[4:0];
			cal_res.hour_out   = msg_s1.cal_hour[4:0];
			cal_res.minute_out = msg_s1.cal_minute[5:0];
			cal_res.second_out = msg_s1.cal_second[5:0];
			cal_res.weekday    = wd;
			cal_res.time_valid = 1'b1;
		end
	end

	// Milliseconds to UTC seconds
	assign ms_prod = MS_PROD_W'(ms_s2) * MS_PROD_W'(MS_RECIP);

	// Apply the zone and classify
	always_comb begin
		zsec     = ({6'd0, zabs_s3} << 6) - ({6'd0, zabs_s3} << 2);
		zsec_ext = SECS_W'(zsec);
		neg_bad  = neg_s3 && (utc_s3 < zsec_ext);
		secs     = neg_s3 ? (utc_s3 - zsec_ext) : (utc_s3 + zsec_ext);
		zone_min = neg_s3 ? (16'd0 - {1'b0, zabs_s3}) : {1'b0, zabs_s3};

		job_d.conv = op_s3 && !neg_bad;
		job_d.secs = secs;
		job_d.res  = op_s3 ? out_t'('0) : res_s3;
	end

	// Stage valid bits and stored zone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			v_s4           <= 1'b0;
			zone_minutes_q <= '0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (v_s3) begin
				zone_minutes_q <= zone_min;
			end
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			msg_s1  <= sync_msg;

			op_s2   <= msg_s1.op;
			ms_s2   <= msg_s1.timestamp_ms;
			neg_s2  <= tz_neg;
			zabs_s2 <= zone_prod[ZONE_SHIFT+ZONE_W-1:ZONE_SHIFT];
			res_s2  <= cal_res;

			op_s3   <= op_s2;
			utc_s3  <= ms_prod[MS_SHIFT+SECS_W-1:MS_SHIFT];
			neg_s3  <= neg_s2;
			zabs_s3 <= zabs_s2;
			res_s3  <= res_s2;

			job_s4  <= job_d;
		end
	end

	`RTSC_ASSERT(a_zone_range,
		($signed(zone_minutes_q) <= $signed({1'b0, ZONE_MAX})) &&
		($signed(zone_minutes_q) >= -$signed({1'b0, ZONE_MAX})),
		"stored zone out of range")
	`RTSC_ASSERT(a_stall_hold, v_s4 && job_full |=> v_s4 && $stable(job_s4),
		"stalled job changed")
	`RTSC_ASSERT_ALWAYS(a_conv_clean, v_s4 && job_s4.conv |-> job_s4.res == out_t'('0),
		"conversion job carries a result")

endmodule
`default_nettype wire

>>> rtl/core/rtsc_queue.sv
// Short job queue between the front end and the converter.
`timescale 1ns / 1ps
`default_nettype none
module rtsc_queue import rtsc_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  job_t wr_data,
	input  logic wr_en,
	output logic full,
	output job_t rd_data,
	input  logic rd_en,
	output logic empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/rtsc_back.sv
// Back end: splits local seconds, walks years and months, holds the output beat.
`timescale 1ns / 1ps
`default_nettype none
`include "rtc_time_sync_converter_macros.svh"
module rtsc_back import rtsc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t job,
	input  logic job_empty,
	output logic job_pop,
	output out_t rtc_cmd,
	output logic empty,
	input  logic pop
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DAYS   = 3'd1;
	localparam logic [2:0] ST_HOURS  = 3'd2;
	localparam logic [2:0] ST_MINS   = 3'd3;
	localparam logic [2:0] ST_YEARS  = 3'd4;
	localparam logic [2:0] ST_MONTHS = 3'd5;
	localparam logic [2:0] ST_EMIT   = 3'd6;

	logic [2:0]        state_q;
	logic [SECS_W-1:0] rem_q;
	logic [DAYS_W-1:0] days_q;
	logic [4:0]        hour_q;
	logic [5:0]        min_q;
	logic [YEAR_W-1:0] year_q;
	logic [3:0]        mon_q;
	out_t              res_q;

	out_t out_q;
	logic out_valid_q;
	logic valid_flag_q;

	logic       out_free;
	logic       load;
	logic       leap;
	logic [8:0] days_ext;
	logic [8:0] diy;
	logic [4:0] dim;
	out_t       unix_res;

	assign out_free = !out_valid_q || pop;
	assign load     = (state_q == ST_EMIT) && out_free;
	assign job_pop  = (state_q == ST_IDLE) && !job_empty;
	assign empty    = !out_valid_q;
	assign rtc_cmd  = out_q;

	// Year and month step values, and the finished Unix result
	always_comb begin
		leap     = leap_year(year_q);
		days_ext = {{(9 - DAYS_W){1'b0}}, days_q};
		diy      = year_days(year_q);
		dim      = month_days(mon_q, leap);

		unix_res            = '0;
		unix_res.rtc_write  = 1'b1;
		unix_res.full_year  = 16'(year_q);
		unix_res.rtc_year   = short_year(16'(year_q));
		unix_res.month_out  = mon_q;
		unix_res.day_out    = 5'(days_ext + 9'd1);
		unix_res.hour_out   = hour_q;
		unix_res.minute_out = min_q;
		unix_res.second_out = rem_q[5:0];
		unix_res.weekday    = 3'd1;
		unix_res.time_valid = 1'b1;
	end

	// Conversion sequencer, one subtract and compare per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						state_q <= job.conv ? ST_DAYS : ST_EMIT;
					end
				end
				ST_DAYS: begin
					if (rem_q < SECS_PER_DAY) begin
						state_q <= ST_HOURS;
					end
				end
				ST_HOURS: begin
					if (rem_q < SECS_PER_HOUR) begin
						state_q <= ST_MINS;
					end
				end
				ST_MINS: begin
					if (rem_q < SECS_PER_MIN) begin
						state_q <= ST_YEARS;
					end
				end
				ST_YEARS: begin
					if (year_q > LAST_YEAR) begin
						state_q <= ST_EMIT;
					end else if (days_ext < diy) begin
						state_q <= ST_MONTHS;
					end
				end
				ST_MONTHS: begin
					if ((mon_q == LAST_MONTH) || (days_ext < 9'(dim))) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Sequencer datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rem_q  <= job.secs;
				days_q <= '0;
				res_q  <= job.res;
			end
			ST_DAYS: begin
				if (rem_q >= SECS_PER_DAY) begin
					rem_q  <= rem_q - SECS_PER_DAY;
					days_q <= days_q + 1'b1;
				end else begin
					hour_q <= '0;
				end
			end
			ST_HOURS: begin
				if (rem_q >= SECS_PER_HOUR) begin
					rem_q  <= rem_q - SECS_PER_HOUR;
					hour_q <= hour_q + 1'b1;
				end else begin
					min_q <= '0;
				end
			end
			ST_MINS: begin
				if (rem_q >= SECS_PER_MIN) begin
					rem_q <= rem_q - SECS_PER_MIN;
					min_q <= min_q + 1'b1;
				end else begin
					year_q <= EPOCH_YEAR;
				end
			end
			ST_YEARS: begin
				if (year_q > LAST_YEAR) begin
					res_q <= '0;
				end else if (days_ext < diy) begin
					mon_q <= 4'd1;
				end else begin
					days_q <= DAYS_W'(days_ext - diy);
					year_q <= year_q + 1'b1;
				end
			end
			ST_MONTHS: begin
				if ((mon_q == LAST_MONTH) || (days_ext < 9'(dim))) begin
					res_q <= unix_res;
				end else begin
					days_q <= DAYS_W'(days_ext - 9'(dim));
					mon_q  <= mon_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Output beat register and time-valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			valid_flag_q <= 1'b0;
		end else if (load) begin
			out_valid_q  <= 1'b1;
			valid_flag_q <= res_q.time_valid;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res_q;
		end
	end

	`RTSC_ASSERT_ALWAYS(a_flag_match, out_valid_q |-> out_q.time_valid == valid_flag_q, "valid flag differs from waiting beat")
	`RTSC_ASSERT(a_pop_busy, job_pop |=> state_q != ST_IDLE, "job taken but sequencer idle")
	`RTSC_ASSERT(a_date_range, out_valid_q && out_q.rtc_write |-> (out_q.month_out >= 4'd1) && (out_q.month_out <= 4'd12) && (out_q.day_out != 5'd0), "written date out of range")

endmodule
`default_nettype wire

>>> rtl/core/rtc_time_sync_converter.sv
// Top level of the time-sync to RTC write converter.
`timescale 1ns / 1ps
`default_nettype none
// Each accepted sync message gives exactly one output beat on rtc_cmd, in order; rtc_write is
// clear in that beat when the message is rejected. A calendar message (op 0) crosses the
// four-stage front pipeline, the job queue and the back end's idle and emit states, and empty
// drops when its beat loads the output register. A Unix message (op 1) also runs through the
// back end's subtract-and-count sequencer, one step per cycle: one per whole day of local time
// (at most 63), per hour (at most 23) and per minute (at most 59), plus a last compare to leave
// each of those loops. 32-bit milliseconds plus the largest zone span under 64 days, so the
// year walk stops in 1970 after one compare and the month walk takes at most three steps. A
// beat that waits to be popped holds the sequencer in its emit step. A queue of QUEUE_DEPTH
// jobs sits between the front and the back, so messages keep being taken while a conversion
// runs and while a finished beat waits to be popped, until the queue and front pipeline fill.
module rtc_time_sync_converter import rtsc_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  in_t  sync_msg,
	input  logic push,
	output logic full,
	output out_t rtc_cmd,
	output logic empty,
	input  logic pop
);

	job_t fq_wr_data;
	logic fq_wr_en;
	logic fq_full;
	job_t fq_rd_data;
	logic fq_rd_en;
	logic fq_empty;

	rtsc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.sync_msg (sync_msg),
		.push     (push),
		.full     (full),
		.job      (fq_wr_data),
		.job_push (fq_wr_en),
		.job_full (fq_full)
	);

	rtsc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_data (fq_wr_data),
		.wr_en   (fq_wr_en),
		.full    (fq_full),
		.rd_data (fq_rd_data),
		.rd_en   (fq_rd_en),
		.empty   (fq_empty)
	);

	rtsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (fq_rd_data),
		.job_empty (fq_empty),
		.job_pop   (fq_rd_en),
		.rtc_cmd   (rtc_cmd),
		.empty     (empty),
		.pop       (pop)
	);

endmodule
`default_nettype wire
